@@ rtl/core/aes_ctr_stream_cipher_unit_macros.svh @@
// Assertion macros shared by the cipher unit
`ifndef AES_CTR_STREAM_CIPHER_UNIT_MACROS_SVH
`define AES_CTR_STREAM_CIPHER_UNIT_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define ACTR_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge
`define ACTR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/actr_pkg.sv @@
// Package: types, constants and AES helper functions for the CTR cipher unit
package actr_pkg;

    localparam int unsigned NumCfgRegs = 7;
    localparam int unsigned RkWords    = 60;
    localparam int unsigned RkAddrW    = 6;

    typedef enum logic [2:0] {
        CFG_KEY0  = 3'd0,
        CFG_KEY1  = 3'd1,
        CFG_KEY2  = 3'd2,
        CFG_KEY3  = 3'd3,
        CFG_KSIZE = 3'd4,
        CFG_IVH   = 3'd5,
        CFG_IVL   = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KS_128 = 2'd0,
        KS_192 = 2'd1,
        KS_256 = 2'd2
    } key_size_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE,
        ST_OUT
    } state_t;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic start;     // load counter XOR round key 0
        logic round_en;  // apply one round
        logic last;      // final round: skip MixColumns
    } round_ctl_t;

    typedef logic [7:0] sbox_arr_t [256];
    localparam sbox_arr_t Sbox = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,
        8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,
        8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,
        8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,
        8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
        8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,8'hd0,8'hef,
        8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,
        8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,
        8'h64,8'h5d,8'h19,8'h73,8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,
        8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,
        8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,8'hba,8'h78,8'h25,8'h2e,
        8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,
        8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,
        8'h28,8'hdf,8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
        8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Key words for a size code; code 3 acts as 256 bits
    function automatic logic [3:0] nk_of(input logic [1:0] mode);
        logic [3:0] n;
        begin
            n = 4'd8;
            if (mode == KS_128) n = 4'd4;
            else if (mode == KS_192) n = 4'd6;
            nk_of = n;
        end
    endfunction

endpackage

@@ rtl/core/actr_if.sv @@
// Valid/ready stream interfaces for input and result bytes
interface actr_in_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_message;
    modport source (output valid, data_byte, last_of_message, input ready);
    modport sink (input valid, data_byte, last_of_message, output ready);
endinterface

interface actr_out_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    modport source (output valid, out_byte, last_out, input ready);
    modport sink (input valid, out_byte, last_out, output ready);
endinterface

@@ rtl/core/actr_key_expand.sv @@
// Iterative key schedule: one round key word per cycle into a word memory
module actr_key_expand (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [255:0]                 key,
    input  logic [1:0]                   mode,
    output logic                         busy,
    input  logic [actr_pkg::RkAddrW-1:0] rd_addr,
    output logic [31:0]                  rd_data
);

    logic [31:0] rk_mem [actr_pkg::RkWords];
    logic [actr_pkg::RkAddrW-1:0] idx_reg, idx_next;
    logic [actr_pkg::RkAddrW-1:0] total_reg;
    logic [3:0]  nk_reg;
    logic [3:0]  phase_reg;  // idx modulo nk
    logic [7:0]  rcon_reg;
    logic [31:0] win_reg [8]; // last nk words, win_reg[0] oldest
    logic        busy_reg;
    logic [31:0] t_word;
    logic [31:0] new_word;
    logic [31:0] wr_word;
    logic [3:0]  nk_w;
    logic [2:0]  top_w;      // window slot of the newest word
    logic        copy_w;     // still copying the key words themselves

    assign nk_w   = actr_pkg::nk_of(mode);
    assign top_w  = 3'(nk_reg - 4'd1);
    assign copy_w = idx_reg < actr_pkg::RkAddrW'(nk_reg);

    // Form the next schedule word from the window
    always_comb
    begin
        t_word = win_reg[top_w];
        if (phase_reg == 4'd0)
        begin
            t_word = actr_pkg::sub_word({t_word[23:0], t_word[31:24]})
                     ^ {rcon_reg, 24'd0};
        end
        else if (nk_reg == 4'd8 && phase_reg == 4'd4)
        begin
            t_word = actr_pkg::sub_word(t_word);
        end
        new_word = win_reg[0] ^ t_word;
        wr_word  = copy_w ? win_reg[idx_reg[2:0]] : new_word;
        idx_next = idx_reg + 1'b1;
    end

    // Advance the expansion one word a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && idx_next == total_reg)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nk_reg    <= nk_w;
            total_reg <= (actr_pkg::RkAddrW'(nk_w) + actr_pkg::RkAddrW'(7))
                         * actr_pkg::RkAddrW'(4);
            idx_reg   <= '0;
            phase_reg <= 4'd0;
            rcon_reg  <= 8'h01;
            for (int i = 0; i < 8; i++)
            begin
                win_reg[i] <= (i < int'(nk_w)) ? key[255-32*i -: 32] : 32'd0;
            end
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_next;
            // Key words are copied first; the window moves only for derived words
            if (!copy_w)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    if (4'(i + 1) < nk_reg) win_reg[i] <= win_reg[i+1];
                end
                win_reg[top_w] <= new_word;
                if (phase_reg == nk_reg - 4'd1)
                begin
                    phase_reg <= 4'd0;
                end
                else
                begin
                    phase_reg <= phase_reg + 4'd1;
                end
                if (phase_reg == 4'd0) rcon_reg <= actr_pkg::xtime(rcon_reg);
            end
        end
    end

    // Write one schedule word per cycle while busy
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rk_mem[idx_reg] <= wr_word;
        end
        rd_data <= rk_mem[rd_addr];
    end

    assign busy = busy_reg | start;

endmodule

@@ rtl/core/actr_round.sv @@
// Shared AES round unit: one round per cycle while round_en is set, on a 128-bit state register
module actr_round (
    input  logic                  clk,
    input  actr_pkg::round_ctl_t  ctl,
    input  logic [127:0]          ctr,
    input  logic [127:0]          rk,
    output logic [127:0]          state
);

    logic [127:0] state_reg, state_next;
    logic [7:0]   sb [16];
    logic [7:0]   sr [16];
    logic [7:0]   mc [16];

    // SubBytes, ShiftRows, optional MixColumns, AddRoundKey
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = actr_pkg::Sbox[state_reg[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sr[4*c+r] = sb[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] all;
            all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c]   = sr[4*c]   ^ all ^ actr_pkg::xtime(sr[4*c]   ^ sr[4*c+1]);
            mc[4*c+1] = sr[4*c+1] ^ all ^ actr_pkg::xtime(sr[4*c+1] ^ sr[4*c+2]);
            mc[4*c+2] = sr[4*c+2] ^ all ^ actr_pkg::xtime(sr[4*c+2] ^ sr[4*c+3]);
            mc[4*c+3] = sr[4*c+3] ^ all ^ actr_pkg::xtime(sr[4*c+3] ^ sr[4*c]);
        end
        for (int i = 0; i < 16; i++)
        begin
            state_next[127-8*i -: 8] = (ctl.last ? sr[i] : mc[i]) ^ rk[127-8*i -: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            state_reg <= ctr ^ rk;
        end
        else if (ctl.round_en)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

@@ rtl/core/aes_ctr_stream_cipher_unit.sv @@
// Top level: AES-CTR byte stream cipher with iterative key schedule and round unit
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+---------------------------------
//  in_ch    | in  | valid/ready | data_byte[7:0], last_of_message
//  out_ch   | out | valid/ready | out_byte[7:0], last_out
//  cfg      | in  | cfg_we      | cfg_index[2:0], cfg_data[63:0]
//
// A byte that uses a buffered keystream byte goes through accept, form and result (IDLE, DONE, OUT).
// Every 16th byte first runs AES: each of the Nr+1 round keys takes 4 word reads through
// the single round key read port, a drain of the last read into the gathered key register,
// and an apply step.
// A config write restarts key expansion: the write is registered into a start strobe, then
// the expander builds the round key schedule, input held off throughout.
// Reset clears control; the key schedule is valid only after a config write.
// The result register holds while out_ch stalls; no new byte is taken meanwhile.
`include "aes_ctr_stream_cipher_unit_macros.svh"

module aes_ctr_stream_cipher_unit (
    input  logic             clk,
    input  logic             rst_n,
    actr_in_if.sink          in_ch,
    actr_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);

    actr_pkg::state_t state_reg, state_next;
    logic [63:0]  key_reg [4];
    logic [1:0]   ksize_reg;
    logic [127:0] iv_reg;
    logic [127:0] ctr_reg;
    logic [127:0] ks_reg;
    logic [4:0]   pos_reg;
    logic [7:0]   data_reg;
    logic         last_reg;
    logic [7:0]   obyte_reg;
    logic         olast_reg;
    logic [3:0]   round_reg;   // current round 0..Nr; Nr+1 after the last round
    logic [1:0]   col_reg;     // round key word within round
    logic [127:0] rk_reg;      // gathered round key
    logic         rd_pend_reg; // a read issued last cycle
    logic [1:0]   rd_col_reg;
    logic         rk_full_reg;
    logic         cfg_hit;
    logic         exp_busy;
    logic [3:0]   nr;
    logic [actr_pkg::RkAddrW-1:0] rd_addr;
    logic [31:0]  rd_data;
    logic [127:0] aes_state;
    actr_pkg::round_ctl_t rctl;
    logic [255:0] key_cat;
    logic [63:0]  ksz_ext;
    logic         issue;

    assign cfg_hit = cfg_we && (cfg_index <= actr_pkg::CFG_IVL);
    assign nr      = actr_pkg::nk_of(ksize_reg) + 4'd6;
    assign key_cat = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    assign ksz_ext = 64'(ksize_reg);

    // Hold configuration registers; a write reloads the key, key size or IV value it addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= 64'd0;
            ksize_reg <= actr_pkg::KS_256;
            iv_reg    <= 128'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                actr_pkg::CFG_KEY0:  key_reg[0] <= cfg_data;
                actr_pkg::CFG_KEY1:  key_reg[1] <= cfg_data;
                actr_pkg::CFG_KEY2:  key_reg[2] <= cfg_data;
                actr_pkg::CFG_KEY3:  key_reg[3] <= cfg_data;
                actr_pkg::CFG_KSIZE: ksize_reg  <= cfg_data[1:0];
                actr_pkg::CFG_IVH:   iv_reg[127:64] <= cfg_data;
                actr_pkg::CFG_IVL:   iv_reg[63:0]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Start expansion in the cycle after the write, once registers hold it
    logic exp_start_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) exp_start_reg <= 1'b0;
        else        exp_start_reg <= cfg_hit;
    end

    actr_key_expand u_expand (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (exp_start_reg),
        .key     (key_cat),
        .mode    (ksize_reg),
        .busy    (exp_busy),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Round key reads: four words per round, registered read data
    assign issue   = (state_reg == actr_pkg::ST_LOAD || state_reg == actr_pkg::ST_ROUND)
                     && !rk_full_reg && !(rd_pend_reg && rd_col_reg == 2'd3);
    assign rd_addr = actr_pkg::RkAddrW'({round_reg, col_reg});

    assign rctl.start    = (state_reg == actr_pkg::ST_LOAD) && rk_full_reg;
    assign rctl.round_en = (state_reg == actr_pkg::ST_ROUND) && rk_full_reg;
    assign rctl.last     = (round_reg == nr);

    actr_round u_round (
        .clk   (clk),
        .ctl   (rctl),
        .ctr   (ctr_reg),
        .rk    (rk_reg),
        .state (aes_state)
    );

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= actr_pkg::ST_IDLE;
        else        state_reg <= state_next;
    end

    // Next state and ready
    always_comb
    begin
        state_next  = state_reg;
        in_ch.ready = 1'b0;
        unique case (state_reg)
            actr_pkg::ST_IDLE:
            begin
                in_ch.ready = !exp_busy && !exp_start_reg && !cfg_hit;
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = (pos_reg[4]) ? actr_pkg::ST_LOAD : actr_pkg::ST_DONE;
                end
            end
            actr_pkg::ST_LOAD:
            begin
                if (rk_full_reg) state_next = actr_pkg::ST_ROUND;
            end
            actr_pkg::ST_ROUND:
            begin
                if (rk_full_reg && round_reg == nr) state_next = actr_pkg::ST_DONE;
            end
            actr_pkg::ST_DONE:
            begin
                state_next = actr_pkg::ST_OUT;
            end
            actr_pkg::ST_OUT:
            begin
                if (out_ch.ready) state_next = actr_pkg::ST_IDLE;
            end
            default: state_next = actr_pkg::ST_IDLE;
        endcase
    end

    // Gather round key words and step the round count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg   <= 4'd0;
            col_reg     <= 2'd0;
            rd_pend_reg <= 1'b0;
            rd_col_reg  <= 2'd0;
            rk_full_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= issue;
            rd_col_reg  <= col_reg;
            if (issue) col_reg <= col_reg + 2'd1;
            if (rd_pend_reg && rd_col_reg == 2'd3) rk_full_reg <= 1'b1;
            if (rctl.start || rctl.round_en)
            begin
                rk_full_reg <= 1'b0;
                round_reg   <= round_reg + 4'd1;
            end
            if (state_reg == actr_pkg::ST_IDLE)
            begin
                round_reg <= 4'd0;
                col_reg   <= 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            rk_reg[127 - 32*rd_col_reg -: 32] <= rd_data;
        end
    end

    // Keystream position, counter and keystream block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 5'd16;
            ctr_reg <= 128'd0;
            ks_reg  <= 128'd0;
        end
        else if (exp_start_reg)
        begin
            ctr_reg <= iv_reg;
            pos_reg <= 5'd16;
        end
        else if (cfg_hit)
        begin
            pos_reg <= 5'd16;
        end
        else if (in_ch.valid && in_ch.ready && pos_reg[4])
        begin
            pos_reg <= 5'd0;
        end
        else if (state_reg == actr_pkg::ST_ROUND && state_next == actr_pkg::ST_DONE)
        begin
            ctr_reg <= ctr_reg + 128'd1;
        end
        else if (state_reg == actr_pkg::ST_DONE)
        begin
            if (round_reg != 4'd0) ks_reg <= aes_state;
        end
        else if (state_reg == actr_pkg::ST_OUT && out_ch.ready)
        begin
            pos_reg <= pos_reg + 5'd1;
        end
    end

    // Capture input; form the result from the fresh or held keystream block
    logic [127:0] ks_use;
    assign ks_use = (round_reg != 4'd0) ? aes_state : ks_reg;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            data_reg <= in_ch.data_byte;
            last_reg <= in_ch.last_of_message;
        end
        if (state_reg == actr_pkg::ST_DONE)
        begin
            obyte_reg <= data_reg ^ ks_use[127 - 8*pos_reg[3:0] -: 8];
            olast_reg <= last_reg;
        end
    end

    assign out_ch.valid    = (state_reg == actr_pkg::ST_OUT);
    assign out_ch.out_byte = obyte_reg;
    assign out_ch.last_out = olast_reg;

    // A fresh block is started only when the position is spent
    `ACTR_ASSERT_IMPL(a_load_pos, clk, rst_n, state_reg == actr_pkg::ST_LOAD && !rk_full_reg && round_reg == 4'd0 && col_reg == 2'd0 && !rd_pend_reg, pos_reg == 5'd0 && ksz_ext <= 64'd3, "block started with unspent keystream")
    // Result stays valid until taken
    `ACTR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(obyte_reg), "result dropped under stall")
    // No input is taken while the key schedule is being built
    `ACTR_ASSERT_IMPL(a_no_accept_exp, clk, rst_n, exp_busy, !(in_ch.valid && in_ch.ready), "byte accepted during key expansion")

endmodule

@@ test/tb_actr_pkg.sv @@
// Package: shared types and constants for the cipher unit testbench
package tb_actr_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    // Longest AES run plus slack, in cycles
    localparam int unsigned BlockCycles  = 120;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } byte_xfer_t;

endpackage

@@ test/tb_actr_if.sv @@
// Stream interfaces used by the testbench live in the RTL; this file holds the config bundle
interface tb_actr_cfg_if (input logic clk);
    logic        we;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output we, index, data);
    modport sink (input we, index, data);
endinterface

@@ test/tb_aes_ctr_stream_cipher_unit.sv @@
// Testbench for the AES-CTR byte stream cipher unit
module tb_aes_ctr_stream_cipher_unit;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    actr_in_if  in_ch (clk);
    actr_out_if out_ch (clk);
    tb_actr_cfg_if cfg (clk);

    aes_ctr_stream_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg.we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data)
    );

    // Predictor state: key registers, counter, keystream and round keys
    logic [63:0] key_reg [4];
    logic [1:0]  ksize_reg;
    logic [63:0] iv_hi_reg;
    logic [63:0] iv_lo_reg;
    logic [127:0] ctr_blk;
    logic [127:0] ks_blk;
    int unsigned  ks_pos;
    logic [31:0]  rkey [60];

    tb_actr_pkg::byte_xfer_t expected_bytes [$];
    int unsigned err_count;
    bit          out_stall_en;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        gmul2 = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        sbox_word = {actr_pkg::Sbox[w[31:24]], actr_pkg::Sbox[w[23:16]],
                     actr_pkg::Sbox[w[15:8]], actr_pkg::Sbox[w[7:0]]};
    endfunction

    function automatic int unsigned key_len_words();
        if (ksize_reg == actr_pkg::KS_128) return 4;
        if (ksize_reg == actr_pkg::KS_192) return 6;
        return 8;
    endfunction

    // Rebuild the round key schedule from the current key registers
    task automatic rebuild_schedule();
        int unsigned nk;
        int unsigned total;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = key_len_words();
        total = 4 * (nk + 7);
        for (int i = 0; i < nk; i++)
            rkey[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        rc = 8'h01;
        for (int i = nk; i < total; i++)
        begin
            t = rkey[i - 1];
            if (i % nk == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul2(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sbox_word(t);
            rkey[i] = rkey[i - nk] ^ t;
        end
    endtask

    function automatic logic [127:0] add_rkey(input logic [127:0] s, input int unsigned rnd);
        add_rkey = s ^ {rkey[4 * rnd], rkey[4 * rnd + 1], rkey[4 * rnd + 2], rkey[4 * rnd + 3]};
    endfunction

    // Encrypt the counter, advance it, and hold the new keystream block
    task automatic next_keystream();
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] v;
        logic [7:0] a0, a1, a2, a3, all;
        int unsigned nr;
        nr = key_len_words() + 6;
        v = add_rkey(ctr_blk, 0);
        for (int r = 1; r <= nr; r++)
        begin
            for (int i = 0; i < 16; i++) s[i] = actr_pkg::Sbox[v[127 - 8 * i -: 8]];
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++) t[4 * c + j] = s[4 * ((c + j) % 4) + j];
            if (r != nr)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4 * c]     = a0 ^ all ^ gmul2(a0 ^ a1);
                    t[4 * c + 1] = a1 ^ all ^ gmul2(a1 ^ a2);
                    t[4 * c + 2] = a2 ^ all ^ gmul2(a2 ^ a3);
                    t[4 * c + 3] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = t[i];
            v = add_rkey(v, r);
        end
        ks_blk = v;
        ctr_blk = ctr_blk + 128'd1;
    endtask

    // Predict the cipher output for one accepted byte
    task automatic predict_cipher_byte(input tb_actr_pkg::byte_xfer_t x);
        tb_actr_pkg::byte_xfer_t y;
        if (ks_pos >= 16)
        begin
            next_keystream();
            ks_pos = 0;
        end
        y.data_byte = x.data_byte ^ ks_blk[127 - 8 * ks_pos -: 8];
        y.last = x.last;
        ks_pos++;
        expected_bytes.push_back(y);
    endtask

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Write one register with the block idle and update the predictor
    task automatic write_reg(input actr_pkg::cfg_idx_t idx, input logic [63:0] value);
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg.we    <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        cfg.we <= 1'b0;
        case (idx)
            actr_pkg::CFG_KEY0:  key_reg[0] = value;
            actr_pkg::CFG_KEY1:  key_reg[1] = value;
            actr_pkg::CFG_KEY2:  key_reg[2] = value;
            actr_pkg::CFG_KEY3:  key_reg[3] = value;
            actr_pkg::CFG_KSIZE: ksize_reg = value[1:0];
            actr_pkg::CFG_IVH:   iv_hi_reg = value;
            default:             iv_lo_reg = value;
        endcase
        rebuild_schedule();
        ctr_blk = {iv_hi_reg, iv_lo_reg};
        ks_pos = 16;
    endtask

    // Send one byte, optionally after a random gap
    task automatic send_byte(input logic [7:0] b, input logic last, input bit idle);
        tb_actr_pkg::byte_xfer_t x;
        int unsigned g;
        g = idle ? gap_len() : 0;
        if (g != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= b;
        in_ch.last_of_message <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        x.data_byte = b;
        x.last = last;
        predict_cipher_byte(x);
    endtask

    task automatic end_stream();
        in_ch.valid <= 1'b0;
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3,
                            input actr_pkg::key_size_t ks, input logic [63:0] ivh, ivl);
        write_reg(actr_pkg::CFG_KEY0, k0);
        write_reg(actr_pkg::CFG_KEY1, k1);
        write_reg(actr_pkg::CFG_KEY2, k2);
        write_reg(actr_pkg::CFG_KEY3, k3);
        write_reg(actr_pkg::CFG_KSIZE, {62'd0, ks});
        write_reg(actr_pkg::CFG_IVH, ivh);
        write_reg(actr_pkg::CFG_IVL, ivl);
    endtask

    // Known vectors, field extremes, and every key size
    task automatic test_directed();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 64'h18191a1b1c1d1e1f, actr_pkg::KS_256, 64'h0, 64'h0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        end_stream();
        write_reg(actr_pkg::CFG_KSIZE, {62'd0, actr_pkg::KS_128});
        for (int i = 0; i < 17; i++) send_byte(8'(i * 37), i[0], 1'b0);
        end_stream();
        write_reg(actr_pkg::CFG_KSIZE, {62'd0, actr_pkg::KS_192});
        send_byte(8'hff, 1'b1, 1'b0);
        end_stream();
        // Key size code three acts as 256 bits
        write_reg(actr_pkg::CFG_KSIZE, 64'd3);
        send_byte(8'h80, 1'b0, 1'b0);
        end_stream();
        // Counter wraps across all 128 bits
        load_key('1, '1, '1, '1, actr_pkg::KS_256, '1, '1);
        for (int i = 0; i < 18; i++) send_byte(8'h01, 1'b0, 1'b0);
        end_stream();
        // Middle-word carry into the upper half
        write_reg(actr_pkg::CFG_IVH, 64'h0);
        write_reg(actr_pkg::CFG_IVL, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 17; i++) send_byte(8'h7f, 1'b1, 1'b0);
        end_stream();
    endtask

    // Random keys and messages, rekeying between phases
    task automatic test_random_stream();
        int unsigned n;
        int unsigned sent;
        actr_pkg::key_size_t ks;
        sent = 0;
        while (sent < 950)
        begin
            ks = actr_pkg::key_size_t'($urandom_range(0, 2));
            load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, ks, {$urandom, $urandom},
                     ($urandom_range(0, 3) == 0) ? 64'hffff_ffff_ffff_fff0
                                                 : {$urandom, $urandom});
            n = $urandom_range(5, 120);
            out_stall_en = $urandom_range(0, 3) != 0;
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom), $urandom_range(0, 7) == 0,
                          $urandom_range(0, 3) != 0);
            end_stream();
            sent += n;
        end
        out_stall_en = 1'b1;
    endtask

    // Receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (!out_stall_en)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                            ($urandom_range(0, 9) == 0 ? 1'b0 : $urandom_range(0, 1));
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        tb_actr_pkg::byte_xfer_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result byte %h last %b",
                         $time, out_ch.out_byte, out_ch.last_out);
                err_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_ch.out_byte !== want.data_byte)
                begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.data_byte, out_ch.out_byte);
                    err_count++;
                end
                if (out_ch.last_out !== want.last)
                begin
                    $display("%0t: last_out expected %b actual %b",
                             $time, want.last, out_ch.last_out);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        err_count = 0;
        out_stall_en = 1'b1;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_of_message = 1'b0;
        cfg.we = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        ksize_reg = actr_pkg::KS_256;
        iv_hi_reg = '0;
        iv_lo_reg = '0;
        ctr_blk = '0;
        ks_blk = '0;
        ks_pos = 16;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream();
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (tb_actr_pkg::BlockCycles) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/actr_pkg.sv
rtl/core/actr_if.sv
rtl/core/actr_key_expand.sv
rtl/core/actr_round.sv
rtl/core/aes_ctr_stream_cipher_unit.sv
test/tb_actr_pkg.sv
test/tb_actr_if.sv
test/tb_aes_ctr_stream_cipher_unit.sv
